// ===== rtl/core/integer_alu_with_power_assert.svh =====
// Assertion macros shared by the ALU RTL files.
`ifndef INTEGER_ALU_WITH_POWER_ASSERT_SVH
`define INTEGER_ALU_WITH_POWER_ASSERT_SVH

// Implication checked every cycle outside reset.
`define IAP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define IAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/iap_pkg.sv =====
// Package: types, codes and constants for the integer ALU.
package iap_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } opcode_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_BADOP = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_req_t;

  // Classified work handed from front to back.
  typedef enum logic [2:0] {
    K_DIRECT = 3'b001,
    K_DIV    = 3'b010,
    K_POW    = 3'b100
  } kind_t;

endpackage

// ===== rtl/core/iap_front.sv =====
// Front end: classifies requests, does add/sub/mul/errors and negative-exponent power, queues work.
module iap_front #(
  parameter int unsigned DATA_WIDTH = iap_pkg::DataWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  iap_pkg::in_req_t      in_data,
  output logic                  q_valid,
  input  logic                  q_ready,
  output iap_pkg::kind_t        q_kind,
  output logic [DATA_WIDTH-1:0] q_a,
  output logic [DATA_WIDTH-1:0] q_b,
  output logic [DATA_WIDTH-1:0] q_res,
  output iap_pkg::status_t      q_st
);
  localparam int unsigned W = DATA_WIDTH;

  // Two-entry queue.
  logic [1:0]     vld_r, vld_nxt;
  iap_pkg::kind_t kind_r [2];
  logic [W-1:0]   a_r [2], b_r [2], res_r [2];
  iap_pkg::status_t st_r [2];
  logic           wp_r, rp_r;

  logic [W-1:0]   a_w, b_w, res_w;
  logic [2*W-1:0] prod_w;
  iap_pkg::kind_t kind_w;
  iap_pkg::status_t st_w;
  logic           push, pop;

  assign in_ready = ~vld_r[wp_r];
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;

  always_comb begin
    // Operands are the low bits of the fields, sign-extended at DATA_WIDTH.
    if (W >= 32) begin
      a_w = W'($signed(in_data.operand_a));
      b_w = W'($signed(in_data.operand_b));
    end else begin
      a_w = W'(in_data.operand_a);
      b_w = W'(in_data.operand_b);
    end
    prod_w = (2*W)'(a_w) * (2*W)'(b_w);
    kind_w = iap_pkg::K_DIRECT;
    st_w   = iap_pkg::ST_OK;
    res_w  = '0;
    case (in_data.opcode)
      iap_pkg::OP_ADD: res_w = a_w + b_w;
      iap_pkg::OP_SUB: res_w = a_w - b_w;
      iap_pkg::OP_MUL: res_w = prod_w[W-1:0];
      iap_pkg::OP_DIV: begin
        if (b_w == '0) st_w = iap_pkg::ST_DIV0;
        else kind_w = iap_pkg::K_DIV;
      end
      iap_pkg::OP_POW: begin
        if (b_w[W-1]) res_w = W'(1);
        else kind_w = iap_pkg::K_POW;
      end
      default: st_w = iap_pkg::ST_BADOP;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (pop)  vld_nxt[rp_r] = 1'b0;
    if (push) vld_nxt[wp_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
    if (push) begin
      kind_r[wp_r] <= kind_w;
      a_r[wp_r]    <= a_w;
      b_r[wp_r]    <= b_w;
      res_r[wp_r]  <= res_w;
      st_r[wp_r]   <= st_w;
    end
  end

  assign q_valid = vld_r[rp_r];
  assign q_kind  = kind_r[rp_r];
  assign q_a     = a_r[rp_r];
  assign q_b     = b_r[rp_r];
  assign q_res   = res_r[rp_r];
  assign q_st    = st_r[rp_r];

  `include "integer_alu_with_power_assert.svh"
  `IAP_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !vld_r[wp_r], "push into full slot")
  `IAP_ASSERT_IMPL(a_ptr_eq, clk, rst_n, wp_r == rp_r, vld_r == 2'b00 || vld_r == 2'b11, "queue pointers inconsistent")
  `IAP_ASSERT_NEXT(a_push_cnt, clk, rst_n, push && !pop, $countones(vld_r) == $past($countones(vld_r)) + 1, "queue count did not rise")

endmodule

// ===== rtl/core/iap_back.sv =====
// Back end: shared iterative divider / square-and-multiply unit and output register.
module iap_back #(
  parameter int unsigned DATA_WIDTH = iap_pkg::DataWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  iap_pkg::kind_t        q_kind,
  input  logic [DATA_WIDTH-1:0] q_a,
  input  logic [DATA_WIDTH-1:0] q_b,
  input  logic [DATA_WIDTH-1:0] q_res,
  input  iap_pkg::status_t      q_st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output iap_pkg::out_req_t     out_data
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_POW  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r;
  logic [W-1:0]   x_r, y_r, acc_r;   // div: dividend-quot/unused/divisor mag; pow: sq/exp/acc
  logic [W-1:0]   rem_r;
  logic           neg_r;
  logic [W-1:0]   res_r;
  iap_pkg::status_t st_r;
  logic           ovld_r;

  logic [W-1:0]   mag_a, mag_b, quot_w;
  logic [W:0]     trial;
  logic [W-1:0]   rem_sh;
  logic [2*W-1:0] mul_acc, mul_sq;
  logic           out_free;

  assign out_free = ~ovld_r | out_ready;
  assign q_ready  = (state_r == S_IDLE);
  assign mag_a    = q_a[W-1] ? (~q_a + W'(1)) : q_a;
  assign mag_b    = q_b[W-1] ? (~q_b + W'(1)) : q_b;

  // Restoring divide step: x_r quotient/dividend shifting, acc_r divisor.
  assign rem_sh  = {rem_r[W-2:0], x_r[W-1]};
  assign trial   = {1'b0, rem_sh} - {1'b0, acc_r};
  assign quot_w  = neg_r ? (~x_r + W'(1)) : x_r;
  // Power step: acc_r accumulator, x_r square, y_r exponent.
  assign mul_acc = (2*W)'(acc_r) * (2*W)'(x_r);
  assign mul_sq  = (2*W)'(x_r) * (2*W)'(x_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) begin
        case (q_kind)
          iap_pkg::K_DIV: state_nxt = S_DIV;
          iap_pkg::K_POW: state_nxt = S_POW;
          default:        state_nxt = S_DONE;
        endcase
      end
      S_DIV, S_POW: if (cnt_r == CW'(W - 1)) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) ovld_r <= 1'b1;
      else if (out_valid && out_ready) ovld_r <= 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        cnt_r <= '0;
        res_r <= q_res;
        st_r  <= q_st;
        rem_r <= '0;
        neg_r <= q_a[W-1] ^ q_b[W-1];
        if (q_kind == iap_pkg::K_DIV) begin
          x_r   <= mag_a;
          acc_r <= mag_b;
        end else begin
          x_r   <= q_a;
          acc_r <= W'(1);
        end
        y_r <= q_b;
      end
      S_DIV: begin
        cnt_r <= cnt_r + CW'(1);
        if (!trial[W]) begin
          rem_r <= trial[W-1:0];
          x_r   <= {x_r[W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          x_r   <= {x_r[W-2:0], 1'b0};
        end
      end
      S_POW: begin
        cnt_r <= cnt_r + CW'(1);
        if (y_r[0]) acc_r <= mul_acc[W-1:0];
        x_r <= mul_sq[W-1:0];
        y_r <= {1'b0, y_r[W-1:1]};
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Result is captured into the output register when leaving S_DONE.
  logic [W-1:0] fin_w;
  logic         was_div_r, was_pow_r;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      was_div_r <= (q_kind == iap_pkg::K_DIV);
      was_pow_r <= (q_kind == iap_pkg::K_POW);
    end
  end
  assign fin_w = was_div_r ? quot_w : (was_pow_r ? acc_r : res_r);

  iap_pkg::out_req_t odata_r;
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      odata_r.result_value <= 32'($signed(fin_w));
      odata_r.status       <= st_r;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  `include "integer_alu_with_power_assert.svh"
  `IAP_ASSERT_IMPL(a_state_hot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `IAP_ASSERT_NEXT(a_done_out, clk, rst_n, state_r == S_DONE && out_free, out_valid, "result lost")
  `IAP_ASSERT_IMPL(a_cnt_rng, clk, rst_n, state_r == S_DIV || state_r == S_POW, cnt_r < CW'(W), "iteration overrun")

endmodule

// ===== rtl/core/integer_alu_with_power.sv =====
// Top level: integer ALU with add, subtract, multiply, divide and power.
// Each request carries an opcode and two signed operands and yields exactly
// one result with a status (ok, divide by zero, invalid opcode). The front
// end classifies every request and finishes add, subtract, multiply, power
// with a negative exponent and the error cases at once. Divide and
// non-negative power go to a shared iterative unit in the back end that does
// one quotient bit or one square-and-multiply step per cycle; that unit sets
// the sustained rate. A two-entry queue between front and back lets the front
// keep accepting while the back works, and an output register holds a
// finished result while the next one is computed.
module integer_alu_with_power #(
  parameter int unsigned DATA_WIDTH = iap_pkg::DataWidth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  iap_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output iap_pkg::out_req_t out_data
);

  // Front-to-back queue head.
  logic                  q_valid, q_ready;
  iap_pkg::kind_t        q_kind;
  logic [DATA_WIDTH-1:0] q_a, q_b, q_res;
  iap_pkg::status_t      q_st;

  iap_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_kind, .q_a, .q_b, .q_res, .q_st
  );

  iap_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_kind, .q_a, .q_b, .q_res, .q_st,
    .out_valid, .out_ready, .out_data
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the integer ALU with power: directed and random requests, checked against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WatchdogLimit = 20000;
  // Opcodes past the last real operation; the package names none of them.
  localparam logic [2:0] OpBadLow = 3'd5;
  localparam logic [2:0] OpBadHigh = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  iap_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  iap_pkg::out_req_t out_data;

  integer_alu_with_power u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  iap_pkg::out_req_t alu_results_due[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  // Idling control: random bursts on both sides until the quiet tail.
  bit          bursty_idle = 1'b1;
  // While set, the receiver's own process holds out_ready low.
  bit          sink_hold = 1'b0;

  // Expected ALU output for one request, at 32 bits.
  function automatic iap_pkg::out_req_t alu_predict(iap_pkg::in_req_t req);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    logic [31:0] acc;
    logic [31:0] sq;
    iap_pkg::out_req_t res;
    a = req.operand_a;
    b = req.operand_b;
    res.result_value = '0;
    res.status = iap_pkg::ST_OK;
    case (req.opcode)
      iap_pkg::OP_ADD: res.result_value = a + b;
      iap_pkg::OP_SUB: res.result_value = a - b;
      iap_pkg::OP_MUL: res.result_value = a * b;
      iap_pkg::OP_DIV: begin
        if (b == '0) begin
          res.status = iap_pkg::ST_DIV0;
        end else begin
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          quo = mag_a / mag_b;
          // Truncate toward zero; min / -1 wraps through the negate.
          res.result_value = (a[31] != b[31]) ? -quo : quo;
        end
      end
      iap_pkg::OP_POW: begin
        acc = 32'd1;
        sq = a;
        if (!b[31]) begin
          for (int i = 0; i < 32; i++) begin
            if (b[i]) acc = acc * sq;
            sq = sq * sq;
          end
        end
        res.result_value = acc;
      end
      default: res.status = iap_pkg::ST_BADOP;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s at result %0d: got %h, want %h", what, results_seen, got, want);
    mismatch_count++;
  endtask

  // Send one request; the predictor queues its result at the accepting edge.
  // Valid stays up after the accept until the next request or an idle gap.
  task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    iap_pkg::in_req_t req;
    req.opcode = op;
    req.operand_a = a;
    req.operand_b = b;
    if (bursty_idle && ($urandom_range(0, 5) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    alu_results_due.push_back(alu_predict(req));
    requests_sent++;
    @(negedge clk);
  endtask

  // Receiver ready: bursty stalls, or a long hold while sink_hold is set.
  initial begin
    int unsigned n;
    @(negedge clk);
    forever begin
      if (sink_hold) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end else if (bursty_idle && ($urandom_range(0, 3) == 0)) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Result checker: compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    iap_pkg::out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (alu_results_due.size() == 0) begin
        report_mismatch("unexpected result", out_data.result_value, 32'h0);
      end else begin
        want = alu_results_due.pop_front();
        if (out_data.result_value !== want.result_value)
          report_mismatch("result_value", out_data.result_value, want.result_value);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  // Watchdog: cycles with no request or result accepted.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n && !sink_hold) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired, %0d results pending", alu_results_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Random 32-bit operand biased toward edge values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 3));
      4: return -32'($urandom_range(1, 100));
      5: return 32'($urandom_range(0, 1000));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    logic [2:0] op;
    // Extremes for every opcode, including the invalid ones.
    for (int k = 0; k < 8; k++) begin
      op = k[2:0];
      send_request(op, 32'h7fff_ffff, 32'h8000_0000);
    end
    send_request(iap_pkg::OP_ADD, 32'h7fff_ffff, 32'd1);          // add wraps
    send_request(iap_pkg::OP_SUB, 32'h8000_0000, 32'd1);          // subtract wraps
    send_request(iap_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
    send_request(iap_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000);  // multiply wraps
    send_request(iap_pkg::OP_DIV, 32'd12345, 32'd0);              // divide by zero
    send_request(iap_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);  // min / -1 wraps
    send_request(iap_pkg::OP_DIV, -32'sd7, 32'sd2);               // truncate toward zero
    send_request(iap_pkg::OP_DIV, 32'sd7, -32'sd2);
    send_request(iap_pkg::OP_POW, 32'd0, 32'd0);                  // zero to the zeroth
    send_request(iap_pkg::OP_POW, 32'd5, -32'sd3);                // negative exponent
    send_request(iap_pkg::OP_POW, 32'd3, 32'd40);                 // power wraps
    send_request(iap_pkg::OP_POW, -32'sd2, 32'd31);
    send_request(iap_pkg::OP_POW, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OpBadLow, $urandom(), $urandom());
    send_request(OpBadHigh, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(int unsigned count);
    logic [2:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      // Mostly legal operations; divide and non-negative power hit the slow unit.
      op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(OpBadLow, OpBadHigh))
                                        : 3'($urandom_range(iap_pkg::OP_ADD, iap_pkg::OP_POW));
      send_request(op, pick_operand(), pick_operand());
    end
  endtask

  // Receiver stalls for a long stretch while slow requests keep coming.
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (400) @(negedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) begin
        send_request(iap_pkg::OP_POW, $urandom(), 32'($urandom_range(0, 64)));
      end
    join
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random(900);
    bursty_idle = 1'b0;
    test_random(120);
    in_valid <= 1'b0;

    // Drain: results already pending, then a latency's worth of spare cycles.
    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d requests over all opcodes, edge operands, divide by zero,",
             requests_sent);
    $display("min/-1, negative exponents and a long output stall; %0d results checked.",
             results_seen);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== integer_alu_with_power.f =====
+incdir+rtl/core
rtl/core/iap_pkg.sv
rtl/core/iap_front.sv
rtl/core/iap_back.sv
rtl/core/integer_alu_with_power.sv
tb/sv/testbench.sv
